// ----- src/rvdec_pkg.sv -----
// Shared types and constants for the RV32IM instruction decoder.
// Opcodes, mnemonic codes, funct3 lookup functions and the decode result struct.
// No dependencies.
`default_nettype none

package rvdec_pkg;

    typedef logic [5:0] mnem_t;

    typedef struct packed {
        mnem_t       code;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] target;
    } dec_result_t;

    // Major opcodes
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;

    // funct3 values used in decode
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Mnemonic codes
    localparam mnem_t CODE_ADD     = 6'd0;
    localparam mnem_t CODE_SUB     = 6'd1;
    localparam mnem_t CODE_AND     = 6'd2;
    localparam mnem_t CODE_OR      = 6'd3;
    localparam mnem_t CODE_XOR     = 6'd4;
    localparam mnem_t CODE_SLL     = 6'd5;
    localparam mnem_t CODE_SRL     = 6'd6;
    localparam mnem_t CODE_SRA     = 6'd7;
    localparam mnem_t CODE_SLT     = 6'd8;
    localparam mnem_t CODE_SLTU    = 6'd9;
    localparam mnem_t CODE_MUL     = 6'd10;
    localparam mnem_t CODE_MULH    = 6'd11;
    localparam mnem_t CODE_MULHSU  = 6'd12;
    localparam mnem_t CODE_MULHU   = 6'd13;
    localparam mnem_t CODE_DIV     = 6'd14;
    localparam mnem_t CODE_DIVU    = 6'd15;
    localparam mnem_t CODE_REM     = 6'd16;
    localparam mnem_t CODE_REMU    = 6'd17;
    localparam mnem_t CODE_ADDI    = 6'd18;
    localparam mnem_t CODE_ANDI    = 6'd19;
    localparam mnem_t CODE_ORI     = 6'd20;
    localparam mnem_t CODE_XORI    = 6'd21;
    localparam mnem_t CODE_SLLI    = 6'd22;
    localparam mnem_t CODE_SRLI    = 6'd23;
    localparam mnem_t CODE_SRAI    = 6'd24;
    localparam mnem_t CODE_LB      = 6'd25;
    localparam mnem_t CODE_LH      = 6'd26;
    localparam mnem_t CODE_LW      = 6'd27;
    localparam mnem_t CODE_LBU     = 6'd28;
    localparam mnem_t CODE_LHU     = 6'd29;
    localparam mnem_t CODE_SB      = 6'd30;
    localparam mnem_t CODE_SH      = 6'd31;
    localparam mnem_t CODE_SW      = 6'd32;
    localparam mnem_t CODE_BEQ     = 6'd33;
    localparam mnem_t CODE_BNE     = 6'd34;
    localparam mnem_t CODE_BLT     = 6'd35;
    localparam mnem_t CODE_BGE     = 6'd36;
    localparam mnem_t CODE_BLTU    = 6'd37;
    localparam mnem_t CODE_BGEU    = 6'd38;
    localparam mnem_t CODE_LUI     = 6'd39;
    localparam mnem_t CODE_AUIPC   = 6'd40;
    localparam mnem_t CODE_JAL     = 6'd41;
    localparam mnem_t CODE_JALR    = 6'd42;
    localparam mnem_t CODE_ECALL   = 6'd43;
    localparam mnem_t CODE_EBREAK  = 6'd44;
    localparam mnem_t CODE_SYSTEM  = 6'd45;
    localparam mnem_t CODE_UNKNOWN = 6'd46;

    function automatic mnem_t op_base_code(input logic [2:0] f3);
        mnem_t c;
        case (f3)
            F3_ADD:  c = CODE_ADD;
            F3_SLL:  c = CODE_SLL;
            F3_SLT:  c = CODE_SLT;
            F3_SLTU: c = CODE_SLTU;
            F3_XOR:  c = CODE_XOR;
            F3_SR:   c = CODE_SRL;
            F3_OR:   c = CODE_OR;
            default: c = CODE_AND;
        endcase
        return c;
    endfunction

    // M extension codes are dense in funct3 order
    function automatic mnem_t op_muldiv_code(input logic [2:0] f3);
        return CODE_MUL + mnem_t'(f3);
    endfunction

    function automatic mnem_t load_code(input logic [2:0] f3);
        mnem_t c;
        case (f3)
            3'd0:    c = CODE_LB;
            3'd1:    c = CODE_LH;
            3'd2:    c = CODE_LW;
            3'd4:    c = CODE_LBU;
            3'd5:    c = CODE_LHU;
            default: c = CODE_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic mnem_t store_code(input logic [2:0] f3);
        mnem_t c;
        case (f3)
            3'd0:    c = CODE_SB;
            3'd1:    c = CODE_SH;
            3'd2:    c = CODE_SW;
            default: c = CODE_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic mnem_t branch_code(input logic [2:0] f3);
        mnem_t c;
        case (f3)
            3'd0:    c = CODE_BEQ;
            3'd1:    c = CODE_BNE;
            3'd4:    c = CODE_BLT;
            3'd5:    c = CODE_BGE;
            3'd6:    c = CODE_BLTU;
            3'd7:    c = CODE_BGEU;
            default: c = CODE_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/rvdec_core.sv -----
// Combinational decode of one RV32IM instruction word.
// Produces mnemonic code, register fields, immediate and branch/jal target.
// Depends on rvdec_pkg.
`default_nettype none

module rvdec_core (
    input  wire logic [31:0]          pc,
    input  wire logic [31:0]          word,
    output rvdec_pkg::dec_result_t    result
);
    import rvdec_pkg::*;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] br_target;
    logic [31:0] jal_target;
    mnem_t       code;
    mnem_t       tbl_code;
    logic [31:0] imm;
    logic [31:0] target;

    assign opc = word[6:0];
    assign f3  = word[14:12];
    assign f7  = word[31:25];

    assign imm_i = {{20{word[31]}}, word[31:20]};
    assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
    assign imm_u = {12'd0, word[31:12]};

    assign br_target  = pc + imm_b;
    assign jal_target = pc + imm_j;

    always_comb
    begin
        code     = CODE_UNKNOWN;
        tbl_code = CODE_UNKNOWN;
        imm      = 32'd0;
        target   = 32'd0;
        case (opc)
            OPC_OP:
            begin
                if (f7 == F7_BASE)
                    code = op_base_code(f3);
                else if (f7 == F7_MULDIV)
                    code = op_muldiv_code(f3);
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    code = CODE_SUB;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    code = CODE_SRA;
            end
            OPC_OPIMM:
            begin
                case (f3)
                    F3_ADD:  code = CODE_ADDI;
                    F3_XOR:  code = CODE_XORI;
                    F3_OR:   code = CODE_ORI;
                    F3_AND:  code = CODE_ANDI;
                    F3_SLL:  code = (f7 == F7_BASE) ? CODE_SLLI : CODE_UNKNOWN;
                    F3_SR:
                    begin
                        if (f7 == F7_BASE)
                            code = CODE_SRLI;
                        else if (f7 == F7_ALT)
                            code = CODE_SRAI;
                    end
                    default: code = CODE_UNKNOWN;
                endcase
                // shift immediates keep the full I-immediate, funct7 included
                if (code != CODE_UNKNOWN)
                    imm = imm_i;
            end
            OPC_LOAD:
            begin
                tbl_code = load_code(f3);
                code     = tbl_code;
                if (tbl_code != CODE_UNKNOWN)
                    imm = imm_i;
            end
            OPC_STORE:
            begin
                tbl_code = store_code(f3);
                code     = tbl_code;
                if (tbl_code != CODE_UNKNOWN)
                    imm = imm_s;
            end
            OPC_BRANCH:
            begin
                tbl_code = branch_code(f3);
                code     = tbl_code;
                if (tbl_code != CODE_UNKNOWN)
                begin
                    imm    = imm_b;
                    target = br_target;
                end
            end
            OPC_LUI:
            begin
                code = CODE_LUI;
                imm  = imm_u;
            end
            OPC_AUIPC:
            begin
                code = CODE_AUIPC;
                imm  = imm_u;
            end
            OPC_JAL:
            begin
                code   = CODE_JAL;
                imm    = imm_j;
                target = jal_target;
            end
            OPC_JALR:
            begin
                code = CODE_JALR;
                imm  = imm_i;
            end
            OPC_SYSTEM:
            begin
                if (word == WORD_ECALL)
                    code = CODE_ECALL;
                else if (word == WORD_EBREAK)
                    code = CODE_EBREAK;
                else
                    code = CODE_SYSTEM;
            end
            default:
            begin
                code = CODE_UNKNOWN;
            end
        endcase
    end

    // field order matches dec_result_t
    assign result = {code, word[11:7], word[19:15], word[24:20], imm, target};

endmodule

`default_nettype wire

// ----- src/rv32im_instruction_decoder.sv -----
// RV32IM instruction decoder: input register, decode logic, result register.
// The result strobe done follows the start transfer through two registers, in_valid_reg then done_reg.
// Throughput: one instruction per cycle; busy is never raised and the receiver cannot stall.
// The result path is a 32-bit pc + offset adder beside the opcode decode, then a select.
// Reset (rst_n low, async) clears the valid bits; no result is strobed for a transfer taken before it.
// Depends on rvdec_pkg and rvdec_core.
`default_nettype none

module rv32im_instruction_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [31:0]        pc_address,
    input  wire logic [31:0]        instruction_word,
    output logic                    done,
    output rvdec_pkg::mnem_t        mnemonic_code,
    output logic [4:0]              dest_reg,
    output logic [4:0]              src1_reg,
    output logic [4:0]              src2_reg,
    output logic signed [31:0]      immediate,
    output logic [31:0]             target_address
);
    import rvdec_pkg::*;

    logic        in_valid_reg;
    logic [31:0] pc_reg;
    logic [31:0] word_reg;
    logic        done_reg;
    dec_result_t res_reg;
    dec_result_t res_next;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pc_reg   <= pc_address;
            word_reg <= instruction_word;
        end
        if (in_valid_reg)
            res_reg <= res_next;
    end

    rvdec_core u_core (
        .pc     (pc_reg),
        .word   (word_reg),
        .result (res_next)
    );

    assign done           = done_reg;
    assign mnemonic_code  = res_reg.code;
    assign dest_reg       = res_reg.rd;
    assign src1_reg       = res_reg.rs1;
    assign src2_reg       = res_reg.rs2;
    assign immediate      = $signed(res_reg.imm);
    assign target_address = res_reg.target;

`ifndef SYNTHESIS
    // every transfer in gives a strobe, registered through in_valid_reg and done_reg
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result strobe missing after start transfer");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(accept, 2))
        else $error("result strobe without a start transfer");

    // target only for branches and jal
    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mnemonic_code != CODE_JAL
            && (mnemonic_code < CODE_BEQ || mnemonic_code > CODE_BGEU))
        |-> target_address == 32'd0)
        else $error("nonzero target for non-branch");

    a_unknown_no_imm: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (mnemonic_code == CODE_UNKNOWN || mnemonic_code == CODE_SYSTEM
            || mnemonic_code == CODE_ECALL || mnemonic_code == CODE_EBREAK))
        |-> immediate == 32'sd0)
        else $error("nonzero immediate for code without one");
`endif

endmodule

`default_nettype wire
